/* rtl/shabh_pkg.sv */
// ----------------------------------------------------------------------------
// shabh_pkg
// Shared types, constants and functions of the SHA-512 block hash.
// ----------------------------------------------------------------------------
package shabh_pkg;

    localparam int WORD_W      = 64;
    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int DIGEST_W    = 8;
    localparam int ROUND_CNT_W = $clog2(ROUNDS);
    localparam int WORD_CNT_W  = $clog2(BLOCK_WORDS);
    localparam int DIGEST_IDX_W = $clog2(DIGEST_W);

    typedef logic [WORD_W-1:0] word_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    // Controls from the sequencer to the round unit.
    typedef struct packed {
        logic init_iv;    // Reload the chaining value with the initial value.
        logic load_vars;  // Copy the chaining value into a..h.
        logic do_round;   // Run one compression round.
        logic fold;       // Add a..h into the chaining value.
    } round_ctl_t;

    // Standard SHA-512 initial hash value.
    function automatic word_t init_value(input logic [DIGEST_IDX_W-1:0] idx);
        word_t r;
        case (idx)
            3'd0:    r = 64'h6a09e667f3bcc908;
            3'd1:    r = 64'hbb67ae8584caa73b;
            3'd2:    r = 64'h3c6ef372fe94f82b;
            3'd3:    r = 64'ha54ff53a5f1d36f1;
            3'd4:    r = 64'h510e527fade682d1;
            3'd5:    r = 64'h9b05688c2b3e6c1f;
            3'd6:    r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t v);
        return rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        return rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        return rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        return rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
    endfunction

    // Round constants.
    function automatic word_t round_k(input logic [ROUND_CNT_W-1:0] t);
        word_t r;
        case (t)
            7'd0:    r = 64'h428A2F98D728AE22;
            7'd1:    r = 64'h7137449123EF65CD;
            7'd2:    r = 64'hB5C0FBCFEC4D3B2F;
            7'd3:    r = 64'hE9B5DBA58189DBBC;
            7'd4:    r = 64'h3956C25BF348B538;
            7'd5:    r = 64'h59F111F1B605D019;
            7'd6:    r = 64'h923F82A4AF194F9B;
            7'd7:    r = 64'hAB1C5ED5DA6D8118;
            7'd8:    r = 64'hD807AA98A3030242;
            7'd9:    r = 64'h12835B0145706FBE;
            7'd10:   r = 64'h243185BE4EE4B28C;
            7'd11:   r = 64'h550C7DC3D5FFB4E2;
            7'd12:   r = 64'h72BE5D74F27B896F;
            7'd13:   r = 64'h80DEB1FE3B1696B1;
            7'd14:   r = 64'h9BDC06A725C71235;
            7'd15:   r = 64'hC19BF174CF692694;
            7'd16:   r = 64'hE49B69C19EF14AD2;
            7'd17:   r = 64'hEFBE4786384F25E3;
            7'd18:   r = 64'h0FC19DC68B8CD5B5;
            7'd19:   r = 64'h240CA1CC77AC9C65;
            7'd20:   r = 64'h2DE92C6F592B0275;
            7'd21:   r = 64'h4A7484AA6EA6E483;
            7'd22:   r = 64'h5CB0A9DCBD41FBD4;
            7'd23:   r = 64'h76F988DA831153B5;
            7'd24:   r = 64'h983E5152EE66DFAB;
            7'd25:   r = 64'hA831C66D2DB43210;
            7'd26:   r = 64'hB00327C898FB213F;
            7'd27:   r = 64'hBF597FC7BEEF0EE4;
            7'd28:   r = 64'hC6E00BF33DA88FC2;
            7'd29:   r = 64'hD5A79147930AA725;
            7'd30:   r = 64'h06CA6351E003826F;
            7'd31:   r = 64'h142929670A0E6E70;
            7'd32:   r = 64'h27B70A8546D22FFC;
            7'd33:   r = 64'h2E1B21385C26C926;
            7'd34:   r = 64'h4D2C6DFC5AC42AED;
            7'd35:   r = 64'h53380D139D95B3DF;
            7'd36:   r = 64'h650A73548BAF63DE;
            7'd37:   r = 64'h766A0ABB3C77B2A8;
            7'd38:   r = 64'h81C2C92E47EDAEE6;
            7'd39:   r = 64'h92722C851482353B;
            7'd40:   r = 64'hA2BFE8A14CF10364;
            7'd41:   r = 64'hA81A664BBC423001;
            7'd42:   r = 64'hC24B8B70D0F89791;
            7'd43:   r = 64'hC76C51A30654BE30;
            7'd44:   r = 64'hD192E819D6EF5218;
            7'd45:   r = 64'hD69906245565A910;
            7'd46:   r = 64'hF40E35855771202A;
            7'd47:   r = 64'h106AA07032BBD1B8;
            7'd48:   r = 64'h19A4C116B8D2D0C8;
            7'd49:   r = 64'h1E376C085141AB53;
            7'd50:   r = 64'h2748774CDF8EEB99;
            7'd51:   r = 64'h34B0BCB5E19B48A8;
            7'd52:   r = 64'h391C0CB3C5C95A63;
            7'd53:   r = 64'h4ED8AA4AE3418ACB;
            7'd54:   r = 64'h5B9CCA4F7763E373;
            7'd55:   r = 64'h682E6FF3D6B2B8A3;
            7'd56:   r = 64'h748F82EE5DEFB2FC;
            7'd57:   r = 64'h78A5636F43172F60;
            7'd58:   r = 64'h84C87814A1F0AB72;
            7'd59:   r = 64'h8CC702081A6439EC;
            7'd60:   r = 64'h90BEFFFA23631E28;
            7'd61:   r = 64'hA4506CEBDE82BDE9;
            7'd62:   r = 64'hBEF9A3F7B2C67915;
            7'd63:   r = 64'hC67178F2E372532B;
            7'd64:   r = 64'hCA273ECEEA26619C;
            7'd65:   r = 64'hD186B8C721C0C207;
            7'd66:   r = 64'hEADA7DD6CDE0EB1E;
            7'd67:   r = 64'hF57D4F7FEE6ED178;
            7'd68:   r = 64'h06F067AA72176FBA;
            7'd69:   r = 64'h0A637DC5A2C898A6;
            7'd70:   r = 64'h113F9804BEF90DAE;
            7'd71:   r = 64'h1B710B35131C471B;
            7'd72:   r = 64'h28DB77F523047D84;
            7'd73:   r = 64'h32CAAB7B40C72493;
            7'd74:   r = 64'h3C9EBE0A15C9BEBC;
            7'd75:   r = 64'h431D67C49C100D4C;
            7'd76:   r = 64'h4CC5D4BECB3E42B6;
            7'd77:   r = 64'h597F299CFC657E2A;
            7'd78:   r = 64'h5FCB6FAB3AD6FAEC;
            7'd79:   r = 64'h6C44198C4A475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/sha512_block_hash.sv */
// ----------------------------------------------------------------------------
// sha512_block_hash
// SHA-512 compression of pre-padded 64-bit message words, sixteen to a block,
// with the digest sent out as eight words after the final block.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  msg       in         msg_valid / msg_stall   msg_word, first_word, final_block
//  digest    out        digest_valid / digest_stall  digest_word, word_index, last_word
//
//  A message word is taken only while the sequencer is idle; the sixteenth word of a block
//  starts the compression rounds and then a fold, run by the single shared round unit.
//  After a final block the eight digest words follow, one per cycle unless stalled;
//  no message word is taken until the last digest word has left.
//  Reset is asynchronous and loads the standard initial hash value.
// ----------------------------------------------------------------------------
module sha512_block_hash (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 msg_valid,
    output logic                                 msg_stall,
    input  shabh_pkg::word_t                     msg_word,
    input  logic                                 first_word,
    input  logic                                 final_block,
    output logic                                 digest_valid,
    input  logic                                 digest_stall,
    output shabh_pkg::word_t                     digest_word,
    output logic [shabh_pkg::DIGEST_IDX_W-1:0]   word_index,
    output logic                                 last_word
);
    import shabh_pkg::*;

    localparam logic [WORD_CNT_W-1:0]   LAST_WORD_CNT  = WORD_CNT_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_CNT_W-1:0]  LAST_ROUND     = ROUND_CNT_W'(ROUNDS - 1);
    localparam logic [DIGEST_IDX_W-1:0] LAST_DIGEST    = DIGEST_IDX_W'(DIGEST_W - 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic [WORD_CNT_W-1:0]     word_cnt_reg;
    logic [WORD_CNT_W-1:0]     word_cnt_next;
    logic [ROUND_CNT_W-1:0]    round_cnt_reg;
    logic [ROUND_CNT_W-1:0]    round_cnt_next;
    logic [DIGEST_IDX_W-1:0]   out_idx_reg;
    logic [DIGEST_IDX_W-1:0]   out_idx_next;
    logic                      final_reg;
    logic                      final_next;
    logic                      msg_take;
    logic                      digest_take;
    logic                      block_done;
    round_ctl_t                ctl;
    word_t                     sched_word;

    assign msg_take    = msg_valid && !msg_stall;
    assign digest_take = digest_valid && !digest_stall;

    // The word that completes a block; a first word always opens a new block.
    assign block_done  = msg_take && !first_word && (word_cnt_reg == LAST_WORD_CNT);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (block_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                state_next = final_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (digest_take && (out_idx_reg == LAST_DIGEST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        msg_stall     = 1'b1;
        digest_valid  = 1'b0;
        ctl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                msg_stall     = 1'b0;
                ctl.init_iv   = msg_take && first_word;
                ctl.load_vars = block_done;
            end
            ST_ROUND:
            begin
                ctl.do_round = 1'b1;
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
            end
            ST_OUT:
            begin
                digest_valid = 1'b1;
            end
            default:
            begin
                msg_stall = 1'b1;
            end
        endcase
    end

    // Counters and the final-block flag.
    always_comb
    begin
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        final_next     = final_reg;
        if (msg_take)
        begin
            word_cnt_next = (first_word ? '0 : word_cnt_reg) + WORD_CNT_W'(1);
            final_next    = final_block;
        end
        if (state_reg == ST_ROUND)
        begin
            round_cnt_next = (round_cnt_reg == LAST_ROUND) ? '0
                                                           : round_cnt_reg + ROUND_CNT_W'(1);
        end
        if (digest_take)
        begin
            out_idx_next = out_idx_reg + DIGEST_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            final_reg     <= final_next;
        end
    end

    // Message schedule.
    shabh_sched u_sched (
        .clk        (clk),
        .shift_in   (msg_take),
        .step       (ctl.do_round),
        .msg_word   (msg_word),
        .sched_word (sched_word)
    );

    // Round unit and chaining value.
    shabh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .round_idx  (round_cnt_reg),
        .sched_word (sched_word),
        .rd_idx     (out_idx_reg),
        .rd_word    (digest_word)
    );

    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == LAST_DIGEST);

endmodule

/* rtl/shabh_sched.sv */
// ----------------------------------------------------------------------------
// shabh_sched
// Message schedule: a sixteen-word shift line that takes message words and
// expands the schedule one word per round.
// ----------------------------------------------------------------------------
module shabh_sched (
    input  logic                 clk,
    input  logic                 shift_in,
    input  logic                 step,
    input  shabh_pkg::word_t     msg_word,
    output shabh_pkg::word_t     sched_word
);
    import shabh_pkg::*;

    // Entry 0 holds the oldest word, W[t] of the current round.
    word_t win_reg [BLOCK_WORDS];
    word_t expand;

    // Next schedule word W[t+16] from the fixed taps.
    assign expand = small_sigma1(win_reg[BLOCK_WORDS-2]) + win_reg[BLOCK_WORDS-7]
                  + small_sigma0(win_reg[1]) + win_reg[0];

    assign sched_word = win_reg[0];

    // Shift line: message words while loading, expanded words while rounding.
    always_ff @(posedge clk)
    begin
        if (shift_in || step)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= shift_in ? msg_word : expand;
        end
    end

endmodule

/* rtl/shabh_round.sv */
// ----------------------------------------------------------------------------
// shabh_round
// Round unit: working variables a..h, one compression round per cycle, and
// the eight-word chaining value.
// ----------------------------------------------------------------------------
module shabh_round (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  shabh_pkg::round_ctl_t                ctl,
    input  logic [shabh_pkg::ROUND_CNT_W-1:0]    round_idx,
    input  shabh_pkg::word_t                     sched_word,
    input  logic [shabh_pkg::DIGEST_IDX_W-1:0]   rd_idx,
    output shabh_pkg::word_t                     rd_word
);
    import shabh_pkg::*;

    word_t var_reg   [DIGEST_W];
    word_t chain_reg [DIGEST_W];
    word_t sel;
    word_t maj;
    word_t t1;
    word_t t2;

    // Round function.
    assign sel = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
    assign t1  = var_reg[7] + big_sigma1(var_reg[4]) + sel + round_k(round_idx) + sched_word;
    assign t2  = big_sigma0(var_reg[0]) + maj;

    assign rd_word = chain_reg[rd_idx];

    // Working variables.
    always_ff @(posedge clk)
    begin
        if (ctl.load_vars)
        begin
            for (int i = 0; i < DIGEST_W; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (ctl.do_round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    // Chaining value: initial value at reset or on a first word, sum after a block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_W; i++)
            begin
                chain_reg[i] <= init_value(DIGEST_IDX_W'(i));
            end
        end
        else if (ctl.init_iv)
        begin
            for (int i = 0; i < DIGEST_W; i++)
            begin
                chain_reg[i] <= init_value(DIGEST_IDX_W'(i));
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < DIGEST_W; i++)
            begin
                chain_reg[i] <= chain_reg[i] + var_reg[i];
            end
        end
    end

endmodule

/* rtl/shabh_checker.sv */
// ----------------------------------------------------------------------------
// shabh_checker
// Port-level checks of the SHA-512 block hash, bound to the top level.
// ----------------------------------------------------------------------------
module shabh_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 msg_stall,
    input  logic                                 digest_valid,
    input  logic                                 digest_stall,
    input  shabh_pkg::word_t                     digest_word,
    input  logic [shabh_pkg::DIGEST_IDX_W-1:0]   word_index,
    input  logic                                 last_word
);
    import shabh_pkg::*;

    // A stalled digest word holds its payload.
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=>
            digest_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest word changed while stalled");

    // The last mark sits on the eighth digest word only.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == DIGEST_IDX_W'(DIGEST_W - 1))))
        else $error("last_word does not match word_index");

    // Digest words follow one another in order without a gap.
    a_digest_order: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !last_word |=>
            digest_valid && (word_index == $past(word_index) + DIGEST_IDX_W'(1)))
        else $error("digest words out of order");

    // No message word is taken while a digest is being sent.
    a_no_msg_in_digest: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> msg_stall)
        else $error("message channel open during digest output");

    // A digest sequence opens at word zero.
    a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (word_index == '0))
        else $error("digest did not start at word zero");

endmodule

bind sha512_block_hash shabh_checker u_shabh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_stall    (msg_stall),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
);

/* sim/sha512_block_hash_tb.sv */
// ----------------------------------------------------------------------------
// sha512_block_hash_tb
// Self-checking bench for the SHA-512 block hash. A short table of directed
// words (a dropped partial block, then the padded empty message against its
// published digest) is followed by random messages of one to three blocks,
// mixed with broken blocks and chained hashes. A local SHA-512 predictor
// works out every digest word, and each word that leaves the block is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module sha512_block_hash_tb;

    localparam int DIR_ROWS     = 20;
    localparam int RANDOM_WORDS = 120;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef shabh_pkg::word_t word_t;
    typedef logic [shabh_pkg::DIGEST_IDX_W-1:0] idx_t;

    // One row of the directed table; known marks a row whose digest is typed in.
    typedef struct packed {
        word_t data;
        logic  first;
        logic  fin;
        logic  known;
    } stim_row_t;

    // One predicted digest word.
    typedef struct packed {
        word_t data;
        idx_t  idx;
        logic  last;
    } digest_rec_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  msg_valid = 1'b0;
    logic  msg_stall;
    word_t msg_word = '0;
    logic  first_word = 1'b0;
    logic  final_block = 1'b0;
    logic  digest_valid;
    logic  digest_stall = 1'b0;
    word_t digest_word;
    idx_t  word_index;
    logic  last_word;

    sha512_block_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_word     (msg_word),
        .first_word   (first_word),
        .final_block  (final_block),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    // SHA-512 round constants.
    word_t round_k_tab [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    // Standard initial hash value.
    word_t start_hash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Published SHA-512 digest of the empty message.
    word_t empty_digest [8] = '{
        64'hcf83e1357eefb8bd, 64'hf1542850d66d8007, 64'hd620e4050b5715dc, 64'h83f4a921d36ce9ce,
        64'h47d0d13c5d85f2b0, 64'hff8318d2877eec2f, 64'h63b931bd47417a81, 64'ha538327af927da3e
    };

    // Directed words: four junk words from the reset state, with the final
    // flag set mid-block, are dropped when the first flag of the empty
    // message arrives; that message carries the final flag on scattered words
    // too, and only its sixteenth word may release the digest.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1, 1'b0},
        '{64'hA5A5A5A55A5A5A5A, 1'b0, 1'b0, 1'b0},
        '{64'h8000000000000000, 1'b1, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b1, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b1, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b1, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b0, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b1, 1'b0},
        '{64'h0000000000000000, 1'b0, 1'b1, 1'b1}
    };

    // Predictor state.
    word_t       chain_h [8];
    word_t       msg_sched [16];
    logic [3:0]  block_fill;
    logic        use_known = 1'b0;
    digest_rec_t digest_expect [$];

    int words_sent    = 0;
    int blocks_hashed = 0;
    int digests_due   = 0;
    int digests_seen  = 0;
    int err_count     = 0;
    int burst_left    = 0;
    int stall_left    = 0;
    int cycle_count   = 0;

    // Clock with a 12-unit period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic word_t ror64(input word_t v, input int unsigned n);
        logic [127:0] d;
        d = {v, v} >> n;
        return d[63:0];
    endfunction

    // Mostly random words, with the all-zero and all-one extremes mixed in.
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Eighty rounds over the schedule window, folded into the chaining value.
    function automatic void compress_chain();
        word_t a, b, c, d, e, f, g, h, w, wm2, wm15, t1, t2;
        int t;
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (t = 0; t < 80; t++)
        begin
            if (t < 16)
            begin
                w = msg_sched[t];
            end
            else
            begin
                wm2  = msg_sched[(t - 2) & 15];
                wm15 = msg_sched[(t - 15) & 15];
                w = (ror64(wm2, 19) ^ ror64(wm2, 61) ^ (wm2 >> 6)) + msg_sched[(t - 7) & 15]
                  + (ror64(wm15, 1) ^ ror64(wm15, 8) ^ (wm15 >> 7)) + msg_sched[t & 15];
                msg_sched[t & 15] = w;
            end
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
               + round_k_tab[t] + w;
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // Take one accepted word into the predictor and queue any digest it releases.
    function automatic void absorb_word(input word_t data, input logic first, input logic fin);
        digest_rec_t r;
        int i;
        if (first)
        begin
            for (i = 0; i < 8; i++)
                chain_h[i] = start_hash[i];
            block_fill = '0;
        end
        msg_sched[block_fill] = data;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0)
        begin
            compress_chain();
            blocks_hashed++;
            if (fin)
            begin
                for (i = 0; i < 8; i++)
                begin
                    r.data = use_known ? empty_digest[i] : chain_h[i];
                    r.idx  = idx_t'(i);
                    r.last = (i == 7);
                    digest_expect.push_back(r);
                    digests_due++;
                end
            end
        end
    endfunction

    // Offer one word in bursts with random gaps; called and returning at a falling edge.
    task automatic send_word(input word_t data, input logic first, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        msg_valid   <= 1'b1;
        msg_word    <= data;
        first_word  <= first;
        final_block <= fin;
        do
            @(posedge clk);
        while (msg_stall !== 1'b0);
        absorb_word(data, first, fin);
        words_sent++;
        @(negedge clk);
    endtask

    // One random message: mostly well-formed, sometimes a broken stub or a
    // chained hash that continues from the previous digest.
    task automatic send_message();
        int kind, nblk, b, i, stub;
        logic fin_all, first, fin;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            stub = $urandom_range(1, 15);
            for (i = 0; i < stub; i++)
                send_word(pick_word(), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end
        else
        begin
            nblk = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1;
            fin_all = 1'($urandom_range(0, 1));
            for (b = 0; b < nblk; b++)
            begin
                for (i = 0; i < 16; i++)
                begin
                    first = (b == 0) && (i == 0) && (kind != 1);
                    if (b == nblk - 1)
                        fin = fin_all || (i == 15);
                    else
                        fin = (i != 15) && ($urandom_range(0, 5) == 0);
                    send_word(pick_word(), first, fin);
                end
            end
        end
    endtask

    // Receiver stalls in runs of random length.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            digest_stall <= ($urandom_range(0, 2) == 0);
            stall_left = $urandom_range(1, 10);
        end
        else
        begin
            stall_left--;
        end
    end

    // Compare each accepted digest word with the oldest prediction.
    always @(posedge clk)
    begin
        digest_rec_t want;
        if (rst_n && digest_valid === 1'b1 && digest_stall == 1'b0)
        begin
            digests_seen++;
            if (digest_expect.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected digest word %h index %0d last %0b",
                             digest_word, word_index, last_word);
            end
            else
            begin
                want = digest_expect.pop_front();
                if (digest_word !== want.data || word_index !== want.idx
                    || last_word !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                                 want.data, want.idx, want.last,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, digest_expect.size());
            $display("sha512_block_hash test failed");
            $finish;
        end
    end

    // Stimulus sequence and final verdict.
    initial
    begin
        int n;
        for (n = 0; n < 8; n++)
            chain_h[n] = start_hash[n];
        for (n = 0; n < 16; n++)
            msg_sched[n] = '0;
        block_fill = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            use_known = dir_rows[n].known;
            send_word(dir_rows[n].data, dir_rows[n].first, dir_rows[n].fin);
            use_known = 1'b0;
        end

        while (words_sent < DIR_ROWS + RANDOM_WORDS)
            send_message();
        msg_valid <= 1'b0;

        while (digest_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d message words, %0d hashed blocks, %0d of %0d digest words checked",
                 words_sent, blocks_hashed, digests_seen, digests_due);
        $display("mismatches or unexpected digest words: %0d", err_count);
        if (err_count == 0)
            $display("sha512_block_hash test passed");
        else
            $display("sha512_block_hash test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/shabh_pkg.sv
rtl/shabh_sched.sv
rtl/shabh_round.sv
rtl/sha512_block_hash.sv
rtl/shabh_checker.sv
sim/sha512_block_hash_tb.sv
